[design/cfs_pkg.sv]
// Package: shared constants, codes and types of the compression format sniffer.
`timescale 1ns / 1ps

package cfs_pkg;

    // Offset counters
    localparam int POS_BITS = 48;
    localparam int OUT_W    = 48;
    localparam int SUM_W    = POS_BITS + 2;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // Result status codes
    localparam logic [1:0] STATUS_IDENTIFIED  = 2'd0;
    localparam logic [1:0] STATUS_NEED_MORE   = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

    // Result method codes
    localparam logic [2:0] METHOD_NONE = 3'd0;
    localparam logic [2:0] METHOD_ZSTD = 3'd1;
    localparam logic [2:0] METHOD_LZ4  = 3'd2;
    localparam logic [2:0] METHOD_GZIP = 3'd3;
    localparam logic [2:0] METHOD_ZLIB = 3'd4;

    // Magic numbers and header bytes
    localparam logic [27:0] SKIP_MAGIC_HI = 28'h184D2A5;
    localparam logic [31:0] MAGIC_ZSTD    = 32'hFD2FB528;
    localparam logic [31:0] MAGIC_LZ4     = 32'h184D2204;
    localparam logic [7:0]  GZIP_ID1      = 8'h1F;
    localparam logic [7:0]  GZIP_ID2      = 8'h8B;
    localparam logic [7:0]  GZIP_CM       = 8'h08;
    localparam logic [3:0]  ZLIB_CM       = 4'h8;

    // Header length offsets used by the need-more report
    localparam logic [3:0] MAGIC_LEN   = 4'd4;
    localparam logic [3:0] SKIP_HDR_LEN = 4'd8;
    // Skip end offset: one byte being consumed plus the next magic
    localparam logic [3:0] SKIP_TAIL   = 4'd5;

    // (CMF * 256) mod 31 for each CINFO value with CM = 8
    localparam logic [4:0] ZLIB_REM [8] = '{
        5'(((16 * 0 + 8) * 256) % 31),
        5'(((16 * 1 + 8) * 256) % 31),
        5'(((16 * 2 + 8) * 256) % 31),
        5'(((16 * 3 + 8) * 256) % 31),
        5'(((16 * 4 + 8) * 256) % 31),
        5'(((16 * 5 + 8) * 256) % 31),
        5'(((16 * 6 + 8) * 256) % 31),
        5'(((16 * 7 + 8) * 256) % 31)
    };

    // Classification of a four-byte frame magic
    typedef struct packed {
        logic       skippable;
        logic [1:0] status;
        logic [2:0] method;
    } t_class;

    // Saturating increment of an offset
    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] a);
        logic [POS_BITS:0] s;
        s = {1'b0, a} + {{POS_BITS{1'b0}}, 1'b1};
        return s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
    endfunction

    // Saturating add of a small constant to an offset
    function automatic logic [POS_BITS-1:0] sat_add_small(input logic [POS_BITS-1:0] a,
                                                          input logic [3:0] b);
        logic [POS_BITS:0] s;
        s = {1'b0, a} + (POS_BITS + 1)'(b);
        return s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
    endfunction

endpackage

[design/cfs_in_if.sv]
// Interface: input byte channel of the compression format sniffer.
`timescale 1ns / 1ps

interface cfs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

[design/cfs_out_if.sv]
// Interface: result channel of the compression format sniffer.
`timescale 1ns / 1ps

interface cfs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  method;
    logic [47:0] need_offset;

    modport source (output valid, output status, output method, output need_offset,
                    input ready);
    modport sink   (input valid, input status, input method, input need_offset,
                    output ready);
endinterface

[design/compression_format_sniffer_top.sv]
// Top level: byte-stream compression format sniffer with skippable-frame stepping.
//
//  Channel  Dir  Payload                              Item
//  i_in     in   kind, data_byte                      one stream byte or end marker
//  o_out    out  status, method, need_offset[47:0]    one decision or need-more report
//
//  One item is taken per cycle; a result appears in the output register the
//  cycle after the item that causes it, set by one state update per byte.
//  i_in.ready drops only while a result is held and o_out.ready is low.
//  Synchronous active-low reset clears the phase, counters and output valid.
//  An end marker rearms the block to the start of a new stream.
`timescale 1ns / 1ps

module compression_format_sniffer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfs_in_if.sink     i_in,
    cfs_out_if.source  o_out
);
    import cfs_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    t_phase                r_phase,      n_phase;
    logic [2:0]            r_hdr_cnt,    n_hdr_cnt;
    logic [6:0][7:0]       r_hdr,        n_hdr;
    logic [31:0]           r_skip_rem,   n_skip_rem;
    logic [POS_BITS-1:0]   r_position,   n_position;
    logic [POS_BITS-1:0]   r_frame,      n_frame;
    logic [POS_BITS-1:0]   r_skip_need,  n_skip_need;
    logic                  r_out_valid,  n_out_valid;
    logic [1:0]            r_status,     n_status;
    logic [2:0]            r_method,     n_method;
    logic [OUT_W-1:0]      r_need,       n_need;

    logic                  in_acc;
    logic [31:0]           magic;
    logic [31:0]           payload;
    logic [POS_BITS-1:0]   pos_inc;
    logic [SUM_W-1:0]      skip_sum;
    t_class                cls;

    // Accept while the output register is free or being emptied
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.method      = r_method;
    assign o_out.need_offset = r_need;

    // Header words complete with the current byte
    assign magic   = {i_in.data_byte, r_hdr[2], r_hdr[1], r_hdr[0]};
    assign payload = {i_in.data_byte, r_hdr[6], r_hdr[5], r_hdr[4]};
    assign pos_inc = sat_inc(r_position);

    // End of payload plus next magic, measured from the current byte
    assign skip_sum = SUM_W'(r_position) + SUM_W'(payload) + SUM_W'(SKIP_TAIL);

    cfs_classify u_classify (
        .i_magic (magic),
        .o_class (cls)
    );

    // Next state and result
    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr       = r_hdr;
        n_skip_rem  = r_skip_rem;
        n_position  = r_position;
        n_frame     = r_frame;
        n_skip_need = r_skip_need;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_method    = r_method;
        n_need      = r_need;
        if (in_acc) begin
            if (i_in.kind) begin
                // Report need-more unless decided, then rearm
                if ((r_phase == PH_HEADER) || (r_phase == PH_SKIP)) begin
                    n_out_valid = 1'b1;
                    n_status    = STATUS_NEED_MORE;
                    n_method    = METHOD_NONE;
                    if (r_phase == PH_SKIP) begin
                        n_need = OUT_W'(r_skip_need);
                    end else begin
                        n_need = OUT_W'(sat_add_small(r_frame,
                                        r_hdr_cnt[2] ? SKIP_HDR_LEN : MAGIC_LEN));
                    end
                end
                n_phase    = PH_HEADER;
                n_hdr_cnt  = '0;
                n_skip_rem = '0;
                n_position = '0;
                n_frame    = '0;
            end else begin
                case (r_phase)
                    PH_SKIP: begin
                        // Count off one payload byte
                        n_position = pos_inc;
                        n_skip_rem = r_skip_rem - 32'd1;
                        if (r_skip_rem == 32'd1) begin
                            n_phase   = PH_HEADER;
                            n_hdr_cnt = '0;
                            n_frame   = pos_inc;
                        end
                    end
                    PH_HEADER: begin
                        // Collect one header byte
                        n_position = pos_inc;
                        n_hdr_cnt  = r_hdr_cnt + 3'd1;
                        if (r_hdr_cnt != 3'd7) begin
                            n_hdr[r_hdr_cnt] = i_in.data_byte;
                        end
                        if ((r_hdr_cnt == 3'd3) && !cls.skippable) begin
                            n_phase     = PH_DONE;
                            n_out_valid = 1'b1;
                            n_status    = cls.status;
                            n_method    = cls.method;
                            n_need      = '0;
                        end
                        if (r_hdr_cnt == 3'd7) begin
                            n_hdr_cnt = '0;
                            if (payload == 32'd0) begin
                                n_frame = pos_inc;
                            end else begin
                                n_phase    = PH_SKIP;
                                n_skip_rem = payload;
                                n_skip_need = (skip_sum[SUM_W-1:POS_BITS] != '0) ?
                                              POS_MAX : skip_sum[POS_BITS-1:0];
                            end
                        end
                    end
                    default: begin
                        // Drop bytes after a decision
                    end
                endcase
            end
        end
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_skip_rem  <= '0;
            r_position  <= '0;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_skip_rem  <= n_skip_rem;
            r_position  <= n_position;
            r_frame     <= n_frame;
            r_out_valid <= n_out_valid;
        end
        r_hdr       <= n_hdr;
        r_skip_need <= n_skip_need;
        r_status    <= n_status;
        r_method    <= n_method;
        r_need      <= n_need;
    end

`ifndef SYNTHESIS
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip_rem != 32'd0))
        else $error("skip phase with no payload left");

    a_need_no_method: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_status == STATUS_NEED_MORE) ||
                         (r_status == STATUS_UNSUPPORTED))) |-> (r_method == METHOD_NONE))
        else $error("method set on a report without identification");

    a_end_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.kind) |=>
            ((r_phase == PH_HEADER) && (r_hdr_cnt == 3'd0) && (r_position == '0)))
        else $error("end marker did not rearm");

    a_done_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in.kind && (r_phase == PH_DONE)) |=>
            ($stable(r_position) && (r_phase == PH_DONE)))
        else $error("byte after decision changed state");

    a_decide_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in.kind && (r_phase == PH_HEADER) && (r_hdr_cnt == 3'd3) &&
         !cls.skippable) |=> (r_out_valid && (r_phase == PH_DONE)))
        else $error("decision without result");
`endif

endmodule

[design/cfs_classify.sv]
// Module: classifies a four-byte little-endian frame magic.
`timescale 1ns / 1ps

module cfs_classify (
    input  logic [31:0]     i_magic,
    output cfs_pkg::t_class o_class
);
    import cfs_pkg::*;

    logic [7:0] cmf;
    logic [7:0] flg;
    logic [6:0] zsum;
    logic       zlib_ok;
    logic       gzip_ok;

    assign cmf = i_magic[7:0];
    assign flg = i_magic[15:8];

    // Fold FLG mod 31 (32 == 1 mod 31) and add the CMF remainder
    assign zsum = 7'(flg[7:5]) + 7'(flg[4:0]) + 7'(ZLIB_REM[cmf[6:4]]);
    assign zlib_ok = (cmf[3:0] == ZLIB_CM) && !cmf[7] &&
                     ((zsum == 7'd0) || (zsum == 7'd31) || (zsum == 7'd62));

    assign gzip_ok = (i_magic[7:0] == GZIP_ID1) && (i_magic[15:8] == GZIP_ID2) &&
                     (i_magic[23:16] == GZIP_CM);

    // Pick the format in priority order
    always_comb begin
        o_class.skippable = (i_magic[31:4] == SKIP_MAGIC_HI);
        o_class.status    = STATUS_IDENTIFIED;
        o_class.method    = METHOD_NONE;
        if (i_magic == MAGIC_ZSTD) begin
            o_class.method = METHOD_ZSTD;
        end else if (i_magic == MAGIC_LZ4) begin
            o_class.method = METHOD_LZ4;
        end else if (gzip_ok) begin
            o_class.method = METHOD_GZIP;
        end else if (zlib_ok) begin
            o_class.method = METHOD_ZLIB;
        end else begin
            o_class.status = STATUS_UNSUPPORTED;
        end
    end

endmodule

[tb/tb.sv]
// Testbench: compression format sniffer, byte streams checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import cfs_pkg::*;

    // Item kinds on the input channel
    localparam bit KIND_BYTE = 1'b0;
    localparam bit KIND_END  = 1'b1;

    // Frame magics, little-endian words
    localparam logic [31:0] SKIPPABLE_FIRST = 32'h184D2A50;
    localparam logic [31:0] SKIPPABLE_LAST  = 32'h184D2A5F;
    localparam logic [31:0] ZSTD_MAGIC      = 32'hFD2FB528;
    localparam logic [31:0] LZ4_MAGIC       = 32'h184D2204;
    localparam logic [7:0]  GZ_ID1          = 8'h1F;
    localparam logic [7:0]  GZ_ID2          = 8'h8B;
    localparam logic [7:0]  GZ_DEFLATE      = 8'h08;
    localparam logic [3:0]  DEFLATE_CM      = 4'h8;
    localparam logic [3:0]  MAX_CINFO       = 4'd7;

    localparam int          OFFSET_W   = 48;
    localparam logic [47:0] OFFSET_TOP = {OFFSET_W{1'b1}};

    localparam int ITEMS_PER_PHASE = 500;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int MAX_REPORTS     = 50;

    typedef enum logic [1:0] {
        SN_HEADER = 2'd0,
        SN_SKIP   = 2'd1,
        SN_DONE   = 2'd2
    } t_sniff_phase;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  method;
        logic [47:0] need;
    } t_sniff_report;

    typedef logic [7:0] t_byte_q[$];

    logic clk;
    logic rst_n;

    cfs_in_if  in_ch ();
    cfs_out_if out_ch ();

    compression_format_sniffer_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state
    logic [63:0]  hdr_window = '0;
    logic [3:0]   hdr_fill   = '0;
    logic [31:0]  skip_left  = '0;
    logic [47:0]  stream_pos = '0;
    t_sniff_phase sn_phase   = SN_HEADER;
    logic [47:0]  frame_at   = '0;

    t_sniff_report pending_reports[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int errors        = 0;

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("compression_format_sniffer_top test failed");
        $finish;
    end

    function automatic logic [47:0] offset_add(input logic [47:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {17'd0, a} + {1'b0, b};
        return (s > {17'd0, OFFSET_TOP}) ? OFFSET_TOP : s[47:0];
    endfunction

    function automatic void rearm_sniffer();
        hdr_window = '0;
        hdr_fill   = '0;
        skip_left  = '0;
        stream_pos = '0;
        sn_phase   = SN_HEADER;
        frame_at   = '0;
    endfunction

    function automatic void open_frame(input logic [47:0] at);
        hdr_window = '0;
        hdr_fill   = '0;
        frame_at   = at;
        sn_phase   = SN_HEADER;
    endfunction

    // Advance the predictor by one accepted item; queue the report it causes
    function automatic void predict_sniff(input bit kind, input logic [7:0] b);
        t_sniff_report r;
        logic [31:0]   magic;
        logic [31:0]   payload;
        logic [7:0]    cmf;
        logic [7:0]    flg;
        r = '0;
        if (kind == KIND_END) begin
            if (sn_phase == SN_HEADER || sn_phase == SN_SKIP) begin
                r.status = STATUS_NEED_MORE;
                r.method = METHOD_NONE;
                if (sn_phase == SN_SKIP)
                    r.need = offset_add(offset_add(stream_pos, {32'd0, skip_left}), 64'd4);
                else if (hdr_fill < 4'd4)
                    r.need = offset_add(frame_at, 64'd4);
                else
                    r.need = offset_add(frame_at, 64'd8);
                pending_reports.push_back(r);
            end
            rearm_sniffer();
            return;
        end
        if (sn_phase != SN_HEADER && sn_phase != SN_SKIP)
            return;
        stream_pos = offset_add(stream_pos, 64'd1);
        // Count off skippable payload
        if (sn_phase == SN_SKIP) begin
            if (skip_left != 32'd0)
                skip_left = skip_left - 32'd1;
            if (skip_left == 32'd0)
                open_frame(stream_pos);
            return;
        end
        hdr_window[hdr_fill[2:0]*8 +: 8] = b;
        hdr_fill = hdr_fill + 4'd1;
        // Classify the magic on the fourth header byte
        if (hdr_fill == 4'd4) begin
            magic = hdr_window[31:0];
            if (magic >= SKIPPABLE_FIRST && magic <= SKIPPABLE_LAST)
                return;
            cmf = hdr_window[7:0];
            flg = hdr_window[15:8];
            r.status = STATUS_IDENTIFIED;
            r.method = METHOD_NONE;
            r.need   = '0;
            if (magic == ZSTD_MAGIC)
                r.method = METHOD_ZSTD;
            else if (magic == LZ4_MAGIC)
                r.method = METHOD_LZ4;
            else if (cmf == GZ_ID1 && flg == GZ_ID2 && hdr_window[23:16] == GZ_DEFLATE)
                r.method = METHOD_GZIP;
            else if (cmf[3:0] == DEFLATE_CM && cmf[7:4] <= MAX_CINFO &&
                     ({cmf, flg} % 16'd31) == 16'd0)
                r.method = METHOD_ZLIB;
            else
                r.status = STATUS_UNSUPPORTED;
            sn_phase = SN_DONE;
            pending_reports.push_back(r);
            return;
        end
        // Skippable header complete: take the payload size
        if (hdr_fill >= 4'd8) begin
            payload = hdr_window[63:32];
            if (payload == 32'd0) begin
                open_frame(stream_pos);
            end else begin
                skip_left  = payload;
                hdr_window = '0;
                hdr_fill   = '0;
                sn_phase   = SN_SKIP;
            end
        end
    endfunction

    // Result checker
    initial begin
        t_sniff_report want;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_reports.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result status=%0d method=%0d need=%0h",
                                 $time, out_ch.status, out_ch.method, out_ch.need_offset);
                end else begin
                    want = pending_reports.pop_front();
                    if (out_ch.status !== want.status) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: status expected %0d actual %0d",
                                     $time, want.status, out_ch.status);
                    end
                    if (out_ch.method !== want.method) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: method expected %0d actual %0d",
                                     $time, want.method, out_ch.method);
                    end
                    if (out_ch.need_offset !== want.need) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: need_offset expected %0h actual %0h",
                                     $time, want.need, out_ch.need_offset);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Send one item, idling first at the current rate, and predict on acceptance
    task automatic send_item(input bit kind, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_sniff(kind, b);
        items_sent++;
    endtask

    task automatic send_stream(input t_byte_q q);
        foreach (q[i])
            send_item(KIND_BYTE, q[i]);
        send_item(KIND_END, 8'($urandom_range(255)));
        // Occasionally a second end marker on an already rearmed block
        if ($urandom_range(14) == 0)
            send_item(KIND_END, 8'($urandom_range(255)));
    endtask

    function automatic void push_word(ref t_byte_q q, input logic [31:0] w);
        q.push_back(w[7:0]);
        q.push_back(w[15:8]);
        q.push_back(w[23:16]);
        q.push_back(w[31:24]);
    endfunction

    // Header of a zlib stream with a valid check field for the given CMF
    function automatic logic [15:0] zlib_pair(input logic [7:0] cmf);
        logic [7:0] flg;
        int         rem;
        flg = 8'($urandom_range(255));
        rem = int'({cmf, flg} % 16'd31);
        if (int'(flg) >= rem)
            flg = flg - 8'(rem);
        else
            flg = flg + 8'(31 - rem);
        return {cmf, flg};
    endfunction

    // Build a random stream: noise, or skippable frames and usually a final header, maybe cut short
    function automatic t_byte_q make_stream();
        t_byte_q     q;
        int          nskip;
        int          pick;
        int          cut;
        logic [31:0] size;
        logic [15:0] zh;
        logic [7:0]  cmf;
        q = {};
        // Plain noise
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(12))
                q.push_back(8'($urandom_range(255)));
            return q;
        end
        pick  = $urandom_range(9);
        nskip = (pick < 5) ? 0 : (pick < 8) ? 1 : (pick == 8) ? 2 : 3;
        repeat (nskip) begin
            push_word(q, SKIPPABLE_FIRST | 32'($urandom_range(15)));
            pick = $urandom_range(9);
            if (pick < 2) begin
                size = '0;
            end else if (pick < 8) begin
                size = $urandom_range(8, 1);
            end else if (pick == 8) begin
                size = $urandom_range(40, 9);
            end else begin
                // Huge payload: the stream ends while skipping
                size = {8'($urandom_range(255, 1)), 24'($urandom)};
                push_word(q, size);
                repeat ($urandom_range(5))
                    q.push_back(8'($urandom_range(255)));
                return q;
            end
            push_word(q, size);
            repeat (size)
                q.push_back(8'($urandom_range(255)));
        end
        // Final frame header
        case ($urandom_range(8))
            0: push_word(q, ZSTD_MAGIC);
            1: push_word(q, LZ4_MAGIC);
            2: push_word(q, {8'($urandom_range(255)), GZ_DEFLATE, GZ_ID2, GZ_ID1});
            3: begin
                zh = zlib_pair({4'($urandom_range(7)), DEFLATE_CM});
                push_word(q, {16'($urandom), zh[7:0], zh[15:8]});
            end
            4: begin
                // zlib near misses: large window, bad check, other method
                pick = $urandom_range(2);
                if (pick == 0)
                    zh = zlib_pair({4'($urandom_range(15, 8)), DEFLATE_CM});
                else if (pick == 1) begin
                    zh = zlib_pair({4'($urandom_range(7)), DEFLATE_CM});
                    zh[7:0] = zh[7:0] + 8'($urandom_range(30, 1));
                end else begin
                    cmf = 8'($urandom_range(255));
                    if (cmf[3:0] == DEFLATE_CM)
                        cmf[0] = 1'b1;
                    zh = zlib_pair(cmf);
                end
                push_word(q, {16'($urandom), zh[7:0], zh[15:8]});
            end
            5: push_word(q, $urandom_range(1) ? SKIPPABLE_FIRST - 32'd1 : SKIPPABLE_LAST + 32'd1);
            6: begin
                // gzip near misses
                if ($urandom_range(1))
                    push_word(q, {8'($urandom), GZ_DEFLATE ^ 8'($urandom_range(255, 1)),
                                  GZ_ID2, GZ_ID1});
                else
                    push_word(q, {8'($urandom), GZ_DEFLATE,
                                  GZ_ID2 ^ 8'($urandom_range(255, 1)), GZ_ID1});
            end
            default: push_word(q, $urandom);
        endcase
        // Bytes after the decision are ignored
        repeat ($urandom_range(3))
            q.push_back(8'($urandom_range(255)));
        // Cut short at a random point
        if ($urandom_range(3) == 0) begin
            cut = $urandom_range(q.size() - 1);
            while (q.size() > cut)
                q.delete(q.size() - 1);
        end
        return q;
    endfunction

    task automatic test_empty_stream();
        send_item(KIND_END, 8'hFF);
    endtask

    task automatic test_decision_then_ignore();
        t_byte_q q;
        q = {8'h28, 8'hB5, 8'h2F, 8'hFD, 8'hFF};
        send_stream(q);
    endtask

    task automatic test_skippable_frames();
        t_byte_q q;
        // Empty skippable payload at the top of the range, then gzip
        q = {8'h5F, 8'h2A, 8'h4D, 8'h18, 8'h00, 8'h00, 8'h00, 8'h00,
             8'h1F, 8'h8B, 8'h08, 8'h00};
        send_stream(q);
        // Bottom of the range, stream ends while skipping
        q = {8'h50, 8'h2A, 8'h4D, 8'h18, 8'h02, 8'h00, 8'h00, 8'h00, 8'hAA};
        send_stream(q);
    endtask

    task automatic test_random_streams(input int send_pct, input int recv_pct);
        int start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = items_sent;
        while (items_sent - start < ITEMS_PER_PHASE)
            send_stream(make_stream());
    endtask

    // Main sequence
    initial begin
        int guard;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.kind      <= KIND_BYTE;
        in_ch.data_byte <= 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 9;
        recv_idle_pct = 86;
        test_empty_stream();
        test_decision_then_ignore();
        test_skippable_frames();
        test_random_streams(9, 86);
        test_random_streams(86, 9);
        test_random_streams(0, 0);
        in_ch.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        guard = 0;
        while (pending_reports.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (pending_reports.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_reports.size());
            errors += pending_reports.size();
        end

        if (errors == 0)
            $display("compression_format_sniffer_top test passed");
        else
            $display("compression_format_sniffer_top test failed");
        $finish;
    end

endmodule

[filelist.f]
design/cfs_pkg.sv
design/cfs_in_if.sv
design/cfs_out_if.sv
design/cfs_classify.sv
design/compression_format_sniffer_top.sv
tb/tb.sv
